FILE: hdl/calu_pkg.sv
// Shared types and codes for the conditional ALU with barrel shifter.
package calu_pkg;

	// One instruction beat as it enters the block.
	typedef struct packed {
		logic [3:0]  condition;
		logic [3:0]  opcode;
		logic        set_flags;
		logic        use_immediate;
		logic [11:0] operand_field;
		logic [31:0] first_value;
		logic [31:0] second_value;
		logic [7:0]  shift_byte;
		logic [3:0]  flags_in;
		logic        thumb_mode;
	} calu_in_t;

	// One result beat as it leaves the block.
	typedef struct packed {
		logic [31:0] result;
		logic        write_result;
		logic [3:0]  flags_out;
		logic        executed;
	} calu_out_t;

	// Data-processing opcodes.
	typedef enum logic [3:0] {
		OP_AND = 4'd0,
		OP_EOR = 4'd1,
		OP_SUB = 4'd2,
		OP_RSB = 4'd3,
		OP_ADD = 4'd4,
		OP_ADC = 4'd5,
		OP_SBC = 4'd6,
		OP_RSC = 4'd7,
		OP_TST = 4'd8,
		OP_TEQ = 4'd9,
		OP_CMP = 4'd10,
		OP_CMN = 4'd11,
		OP_ORR = 4'd12,
		OP_MOV = 4'd13,
		OP_BIC = 4'd14,
		OP_MVN = 4'd15
	} calu_op_t;

	// Shift types from the operand field.
	localparam logic [1:0] SH_LSL = 2'd0;
	localparam logic [1:0] SH_LSR = 2'd1;
	localparam logic [1:0] SH_ASR = 2'd2;
	localparam logic [1:0] SH_ROR = 2'd3;

	// Condition codes.
	localparam logic [3:0] COND_EQ = 4'd0;
	localparam logic [3:0] COND_NE = 4'd1;
	localparam logic [3:0] COND_CS = 4'd2;
	localparam logic [3:0] COND_CC = 4'd3;
	localparam logic [3:0] COND_MI = 4'd4;
	localparam logic [3:0] COND_PL = 4'd5;
	localparam logic [3:0] COND_VS = 4'd6;
	localparam logic [3:0] COND_VC = 4'd7;
	localparam logic [3:0] COND_HI = 4'd8;
	localparam logic [3:0] COND_LS = 4'd9;
	localparam logic [3:0] COND_GE = 4'd10;
	localparam logic [3:0] COND_LT = 4'd11;
	localparam logic [3:0] COND_GT = 4'd12;
	localparam logic [3:0] COND_LE = 4'd13;

	// Flag bit positions in an NZCV nibble.
	localparam int FLAG_N = 3;
	localparam int FLAG_Z = 2;
	localparam int FLAG_C = 1;
	localparam int FLAG_V = 0;

endpackage

FILE: hdl/calu_shifter.sv
// Barrel shifter that forms operand 2 and its shifter carry.
module calu_shifter import calu_pkg::*; (
	input  logic        use_immediate,
	input  logic        thumb_mode,
	input  logic [11:0] operand_field,
	input  logic [31:0] value,
	input  logic [7:0]  shift_byte,
	input  logic        carry_in,
	output logic [31:0] operand,
	output logic        carry
);

	logic [1:0]  sh_type;
	logic [4:0]  mid_amt;
	logic [31:0] mid_val;
	logic        mid_cy;
	logic [32:0] lsl_w;
	logic [32:0] lsr_w;
	logic [32:0] asr_w;
	logic [31:0] ror_w;
	logic [4:0]  rot_amt;
	logic [31:0] imm_rot;
	logic        sign;

	assign sh_type = operand_field[6:5];
	assign sign    = value[31];
	// By register the low five bits of the byte count; by immediate bits 11..7.
	assign mid_amt = operand_field[4] ? shift_byte[4:0] : operand_field[11:7];

	// Shift by 1..31; the extra bit catches the last bit shifted out.
	always_comb begin
		lsl_w = {1'b0, value} << mid_amt;
		lsr_w = {value, 1'b0} >> mid_amt;
		asr_w = 33'($signed({value, 1'b0}) >>> mid_amt);
		ror_w = (value >> mid_amt) | (value << (6'd32 - {1'b0, mid_amt}));
		case (sh_type)
			SH_LSL: begin
				mid_val = lsl_w[31:0];
				mid_cy  = lsl_w[32];
			end
			SH_LSR: begin
				mid_val = lsr_w[32:1];
				mid_cy  = lsr_w[0];
			end
			SH_ASR: begin
				mid_val = asr_w[32:1];
				mid_cy  = asr_w[0];
			end
			default: begin
				mid_val = ror_w;
				mid_cy  = ror_w[31];
			end
		endcase
	end

	// Rotated 8-bit immediate, rotate amount is twice the field.
	assign rot_amt = {operand_field[11:8], 1'b0};
	assign imm_rot = ({24'd0, operand_field[7:0]} >> rot_amt)
		| ({24'd0, operand_field[7:0]} << (6'd32 - {1'b0, rot_amt}));

	// Select the operand and carry for each encoding and special amount.
	always_comb begin
		operand = value;
		carry   = carry_in;
		if (use_immediate) begin
			if (thumb_mode) begin
				operand = {20'd0, operand_field};
			end else if (rot_amt != 5'd0) begin
				operand = imm_rot;
				carry   = imm_rot[31];
			end else begin
				operand = {24'd0, operand_field[7:0]};
			end
		end else if (operand_field[4]) begin
			if (shift_byte == 8'd0) begin
				operand = value;
			end else if (shift_byte[7:5] == 3'd0) begin
				operand = mid_val;
				carry   = mid_cy;
			end else begin
				case (sh_type)
					SH_LSL: begin
						operand = 32'd0;
						carry   = (shift_byte == 8'd32) ? value[0] : 1'b0;
					end
					SH_LSR: begin
						operand = 32'd0;
						carry   = (shift_byte == 8'd32) ? sign : 1'b0;
					end
					SH_ASR: begin
						operand = {32{sign}};
						carry   = sign;
					end
					default: begin
						// A multiple of 32 rotates to itself with carry from bit 31.
						operand = mid_val;
						carry   = mid_cy;
					end
				endcase
			end
		end else if (mid_amt != 5'd0) begin
			operand = mid_val;
			carry   = mid_cy;
		end else begin
			// Immediate amount of zero: LSR and ASR act as 32, ROR is RRX.
			case (sh_type)
				SH_LSL: begin
					operand = value;
				end
				SH_LSR: begin
					operand = 32'd0;
					carry   = sign;
				end
				SH_ASR: begin
					operand = {32{sign}};
					carry   = sign;
				end
				default: begin
					operand = {carry_in, value[31:1]};
					carry   = value[0];
				end
			endcase
		end
	end

endmodule

FILE: hdl/calu_alu.sv
// ALU for the sixteen data-processing opcodes with carry and overflow.
module calu_alu import calu_pkg::*; (
	input  logic [3:0]  opcode,
	input  logic [31:0] op_a,
	input  logic [31:0] op_b,
	input  logic        shift_carry,
	input  logic        carry_in,
	input  logic        overflow_in,
	output logic [31:0] result,
	output logic        carry,
	output logic        overflow
);

	logic        arith;
	logic [31:0] add_p;
	logic [31:0] add_q;
	logic        add_k;
	logic [32:0] sum;

	// Pick adder inputs for arithmetic codes, logic result for the rest.
	always_comb begin
		arith = 1'b0;
		add_p = op_a;
		add_q = op_b;
		add_k = 1'b0;
		result = 32'd0;
		case (opcode) inside
			OP_AND, OP_TST: result = op_a & op_b;
			OP_EOR, OP_TEQ: result = op_a ^ op_b;
			OP_SUB, OP_CMP: begin
				arith = 1'b1; add_q = ~op_b; add_k = 1'b1;
			end
			OP_RSB: begin
				arith = 1'b1; add_p = op_b; add_q = ~op_a; add_k = 1'b1;
			end
			OP_ADD, OP_CMN: begin
				arith = 1'b1;
			end
			OP_ADC: begin
				arith = 1'b1; add_k = carry_in;
			end
			OP_SBC: begin
				arith = 1'b1; add_q = ~op_b; add_k = carry_in;
			end
			OP_RSC: begin
				arith = 1'b1; add_p = op_b; add_q = ~op_a; add_k = carry_in;
			end
			OP_ORR: result = op_a | op_b;
			OP_MOV: result = op_b;
			OP_BIC: result = op_a & ~op_b;
			default: result = ~op_b;
		endcase
		sum = {1'b0, add_p} + {1'b0, add_q} + {32'd0, add_k};
		carry    = shift_carry;
		overflow = overflow_in;
		if (arith) begin
			result   = sum[31:0];
			carry    = sum[32];
			overflow = (add_p[31] ^ sum[31]) & (add_q[31] ^ sum[31]);
		end
	end

endmodule

FILE: hdl/cond_alu_with_barrel_shifter.sv
// Top level: conditional ALU with barrel shifter, one register stage each side.
//
// Usage: drive the instruction fields and operand values on cmd and raise
// start. A beat is taken at each rising edge where start is high and busy is
// low; busy is never raised, so a new beat can be taken in every cycle.
// The block registers the beat, tests the condition against flags_in, forms
// operand 2 in the barrel shifter, runs the ALU and registers the outcome.
// The outcome appears on rsp with done high for exactly one cycle, after the
// beat has passed the input register and the result register (throughput 1
// per cycle).
// The path between the two registers is the shifter followed by the 32-bit
// adder and the flag logic.
// A beat that fails its condition still yields one outcome with executed,
// write_result and result at zero and the flags passed through.
// The receiver cannot stall: rsp must be taken in the cycle done is high.
// Reset clears both stage valid bits, so no outcome is shown after reset
// until a new beat has been taken.
module cond_alu_with_barrel_shifter import calu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  calu_in_t  cmd,
	output logic      done,
	output calu_out_t rsp
);

	logic      valid_s1;
	calu_in_t  cmd_s1;
	logic      valid_s2;
	calu_out_t rsp_s2;
	logic      cond_ok;
	logic [31:0] operand2;
	logic      shift_cy;
	logic [31:0] alu_res;
	logic      alu_c;
	logic      alu_v;
	logic      is_test;
	calu_out_t rsp_next;
	logic      fn;
	logic      fz;
	logic      fc;
	logic      fv;

	assign busy = 1'b0;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start & ~busy) begin
			cmd_s1 <= cmd;
		end
	end

	assign fn = cmd_s1.flags_in[FLAG_N];
	assign fz = cmd_s1.flags_in[FLAG_Z];
	assign fc = cmd_s1.flags_in[FLAG_C];
	assign fv = cmd_s1.flags_in[FLAG_V];

	// Condition test; codes 14 and 15, which the package leaves unnamed, count as always.
	always_comb begin
		unique case (cmd_s1.condition)
			COND_EQ: cond_ok = fz;
			COND_NE: cond_ok = ~fz;
			COND_CS: cond_ok = fc;
			COND_CC: cond_ok = ~fc;
			COND_MI: cond_ok = fn;
			COND_PL: cond_ok = ~fn;
			COND_VS: cond_ok = fv;
			COND_VC: cond_ok = ~fv;
			COND_HI: cond_ok = fc & ~fz;
			COND_LS: cond_ok = ~fc | fz;
			COND_GE: cond_ok = (fn == fv);
			COND_LT: cond_ok = (fn != fv);
			COND_GT: cond_ok = ~fz & (fn == fv);
			COND_LE: cond_ok = fz | (fn != fv);
			default: cond_ok = 1'b1;
		endcase
	end

	calu_shifter u_shifter (
		.use_immediate (cmd_s1.use_immediate),
		.thumb_mode    (cmd_s1.thumb_mode),
		.operand_field (cmd_s1.operand_field),
		.value         (cmd_s1.second_value),
		.shift_byte    (cmd_s1.shift_byte),
		.carry_in      (fc),
		.operand       (operand2),
		.carry         (shift_cy)
	);

	calu_alu u_alu (
		.opcode      (cmd_s1.opcode),
		.op_a        (cmd_s1.first_value),
		.op_b        (operand2),
		.shift_carry (shift_cy),
		.carry_in    (fc),
		.overflow_in (fv),
		.result      (alu_res),
		.carry       (alu_c),
		.overflow    (alu_v)
	);

	// Compare and test opcodes do not write the destination.
	always_comb begin
		case (cmd_s1.opcode) inside
			OP_TST, OP_TEQ, OP_CMP, OP_CMN: is_test = 1'b1;
			default: is_test = 1'b0;
		endcase
	end

	// Assemble the outcome; a failed condition passes the flags through.
	always_comb begin
		rsp_next.result       = 32'd0;
		rsp_next.write_result = 1'b0;
		rsp_next.flags_out    = cmd_s1.flags_in;
		rsp_next.executed     = 1'b0;
		if (cond_ok) begin
			rsp_next.result       = alu_res;
			rsp_next.write_result = ~is_test;
			rsp_next.executed     = 1'b1;
			if (cmd_s1.set_flags) begin
				rsp_next.flags_out = {alu_res[31], (alu_res == 32'd0), alu_c, alu_v};
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp_s2 <= rsp_next;
		end
	end

	assign done = valid_s2;
	assign rsp  = rsp_s2;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the conditional ALU with barrel shifter.
`timescale 1ns / 100ps

module tb import calu_pkg::*;;

	// Condition codes that the package leaves unnamed.
	localparam logic [3:0] COND_AL = 4'd14;
	localparam logic [3:0] COND_ALWAYS = 4'd15;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	calu_in_t  cmd;
	logic      done;
	calu_out_t rsp;

	// Outcomes predicted for accepted beats, oldest first.
	calu_out_t outcomes_due[$];
	int        mismatch_count = 0;
	int        sender_hold_pct = 0;

	cond_alu_with_barrel_shifter uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.rsp    (rsp)
	);

	// Free-running clock, 4 ns period.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: the slowest correct run is far shorter than this.
	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// ------------------------------------------------------------------
	// Behavioral model of the execute stage.
	// ------------------------------------------------------------------

	function automatic logic [31:0] rotate_right(logic [31:0] x, int n);
		int r;
		r = n & 31;
		if (r == 0)
			return x;
		return (x >> r) | (x << (32 - r));
	endfunction

	function automatic logic condition_holds(logic [3:0] cc, logic [3:0] f);
		logic n, z, c, v;
		n = f[FLAG_N];
		z = f[FLAG_Z];
		c = f[FLAG_C];
		v = f[FLAG_V];
		case (cc)
			COND_EQ: return z;
			COND_NE: return !z;
			COND_CS: return c;
			COND_CC: return !c;
			COND_MI: return n;
			COND_PL: return !n;
			COND_VS: return v;
			COND_VC: return !v;
			COND_HI: return c && !z;
			COND_LS: return !c || z;
			COND_GE: return n == v;
			COND_LT: return n != v;
			COND_GT: return !z && (n == v);
			COND_LE: return z || (n != v);
			default: return 1'b1;
		endcase
	endfunction

	// Shift by an amount from 1 to 31, giving the shifter carry out.
	function automatic logic [31:0] shift_partial(logic [1:0] kind, logic [31:0] x, int amt,
			output logic cy);
		case (kind)
			SH_LSL: begin
				cy = x[32 - amt];
				return x << amt;
			end
			SH_LSR: begin
				cy = x[amt - 1];
				return x >> amt;
			end
			SH_ASR: begin
				cy = x[amt - 1];
				return $signed(x) >>> amt;
			end
			default: begin
				cy = x[amt - 1];
				return rotate_right(x, amt);
			end
		endcase
	endfunction

	function automatic calu_out_t alu_outcome(calu_in_t c);
		calu_out_t   o;
		logic [31:0] a, x, b, res, p, q;
		logic [32:0] sum;
		logic [1:0]  kind;
		logic        cin, cy, cflag, vflag, k, arith;
		int          amt;
		a = c.first_value;
		x = c.second_value;
		cin = c.flags_in[FLAG_C];
		cy = cin;
		arith = 1'b0;
		p = '0;
		q = '0;
		k = 1'b0;
		res = '0;
		b = '0;

		// A failed condition passes the flags through and writes nothing.
		if (!condition_holds(c.condition, c.flags_in)) begin
			o.result = '0;
			o.write_result = 1'b0;
			o.flags_out = c.flags_in;
			o.executed = 1'b0;
			return o;
		end

		// Operand 2 from the barrel shifter.
		kind = c.operand_field[6:5];
		if (c.use_immediate) begin
			if (c.thumb_mode) begin
				b = {20'd0, c.operand_field};
			end else begin
				amt = c.operand_field[11:8] * 2;
				b = {24'd0, c.operand_field[7:0]};
				if (amt != 0) begin
					b = rotate_right(b, amt);
					cy = b[31];
				end
			end
		end else if (c.operand_field[4]) begin
			amt = c.shift_byte;
			if (amt == 0) begin
				b = x;
			end else if (amt < 32) begin
				b = shift_partial(kind, x, amt, cy);
			end else begin
				case (kind)
					SH_LSL: begin
						cy = (amt == 32) ? x[0] : 1'b0;
						b = '0;
					end
					SH_LSR: begin
						cy = (amt == 32) ? x[31] : 1'b0;
						b = '0;
					end
					SH_ASR: begin
						cy = x[31];
						b = {32{x[31]}};
					end
					default: begin
						// A nonzero multiple of 32 leaves the operand whole.
						amt = amt & 31;
						if (amt == 0) begin
							cy = x[31];
							b = x;
						end else begin
							b = shift_partial(SH_ROR, x, amt, cy);
						end
					end
				endcase
			end
		end else begin
			amt = c.operand_field[11:7];
			if (amt != 0) begin
				b = shift_partial(kind, x, amt, cy);
			end else begin
				// A zero immediate amount encodes LSL #0, shifts by 32, and RRX.
				case (kind)
					SH_LSL: b = x;
					SH_LSR: begin
						cy = x[31];
						b = '0;
					end
					SH_ASR: begin
						cy = x[31];
						b = {32{x[31]}};
					end
					default: begin
						cy = x[0];
						b = {cin, x[31:1]};
					end
				endcase
			end
		end

		// ALU operation.
		case (calu_op_t'(c.opcode))
			OP_AND, OP_TST: res = a & b;
			OP_EOR, OP_TEQ: res = a ^ b;
			OP_SUB, OP_CMP: begin
				arith = 1'b1; p = a; q = ~b; k = 1'b1;
			end
			OP_RSB: begin
				arith = 1'b1; p = b; q = ~a; k = 1'b1;
			end
			OP_ADD, OP_CMN: begin
				arith = 1'b1; p = a; q = b; k = 1'b0;
			end
			OP_ADC: begin
				arith = 1'b1; p = a; q = b; k = cin;
			end
			OP_SBC: begin
				arith = 1'b1; p = a; q = ~b; k = cin;
			end
			OP_RSC: begin
				arith = 1'b1; p = b; q = ~a; k = cin;
			end
			OP_ORR: res = a | b;
			OP_MOV: res = b;
			OP_BIC: res = a & ~b;
			default: res = ~b;
		endcase

		// Logical operations take C from the shifter and keep V.
		cflag = cy;
		vflag = c.flags_in[FLAG_V];
		if (arith) begin
			sum = {1'b0, p} + {1'b0, q} + {32'd0, k};
			res = sum[31:0];
			cflag = sum[32];
			vflag = (p[31] ^ res[31]) & (q[31] ^ res[31]);
		end

		o.result = res;
		o.executed = 1'b1;
		case (calu_op_t'(c.opcode))
			OP_TST, OP_TEQ, OP_CMP, OP_CMN: o.write_result = 1'b0;
			default: o.write_result = 1'b1;
		endcase
		if (c.set_flags)
			o.flags_out = {res[31], res == 32'd0, cflag, vflag};
		else
			o.flags_out = c.flags_in;
		return o;
	endfunction

	// ------------------------------------------------------------------
	// Result checking.
	// ------------------------------------------------------------------

	task automatic note_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("MISMATCH at %0t: %s", $realtime, what);
	endtask

	// Each result beat is compared with the oldest outstanding prediction.
	always @(posedge clk) begin
		calu_out_t want;
		if (arst_n && done) begin
			if (outcomes_due.size() == 0) begin
				note_mismatch($sformatf("result beat with nothing outstanding: %p", rsp));
			end else begin
				want = outcomes_due.pop_front();
				if (rsp.result !== want.result)
					note_mismatch($sformatf("result expected %h actual %h",
						want.result, rsp.result));
				if (rsp.write_result !== want.write_result)
					note_mismatch($sformatf("write_result expected %b actual %b",
						want.write_result, rsp.write_result));
				if (rsp.flags_out !== want.flags_out)
					note_mismatch($sformatf("flags_out expected %b actual %b",
						want.flags_out, rsp.flags_out));
				if (rsp.executed !== want.executed)
					note_mismatch($sformatf("executed expected %b actual %b",
						want.executed, rsp.executed));
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_beat(input calu_in_t beat);
		while ($urandom_range(99) < sender_hold_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		cmd <= beat;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		outcomes_due.push_back(alu_outcome(beat));
		@(negedge clk);
	endtask

	// Hold off the sender until every outstanding result has arrived.
	task automatic drain_outcomes();
		start <= 1'b0;
		@(negedge clk);
		while (outcomes_due.size() != 0)
			@(negedge clk);
	endtask

	function automatic calu_in_t make_instr(logic [3:0] cc, calu_op_t op, logic s,
			logic imm, logic [11:0] fld, logic [31:0] a, logic [31:0] x,
			logic [7:0] sb, logic [3:0] f, logic th);
		calu_in_t c;
		c.condition = cc;
		c.opcode = op;
		c.set_flags = s;
		c.use_immediate = imm;
		c.operand_field = fld;
		c.first_value = a;
		c.second_value = x;
		c.shift_byte = sb;
		c.flags_in = f;
		c.thumb_mode = th;
		return c;
	endfunction

	// Operand field for a register shifted by an immediate amount.
	function automatic logic [11:0] shift_by_amount(logic [4:0] amt, logic [1:0] kind);
		return {amt, kind, 1'b0, 4'd0};
	endfunction

	// Operand field for a register shifted by the shift byte.
	function automatic logic [11:0] shift_by_byte(logic [1:0] kind);
		return {4'd0, 1'b0, kind, 1'b1, 4'd0};
	endfunction

	// Operand values biased toward the corners of the adder and shifter.
	function automatic logic [31:0] random_word();
		case ($urandom_range(7))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return 32'h8000_0000;
			3: return 32'h7fff_ffff;
			4: return 32'h0000_0001;
			default: return $urandom;
		endcase
	endfunction

	function automatic calu_in_t random_instr();
		calu_in_t c;
		c.condition = ($urandom_range(99) < 40) ? (($urandom_range(1) != 0) ? COND_AL :
			COND_ALWAYS) : 4'($urandom_range(15));
		c.opcode = 4'($urandom_range(15));
		c.set_flags = 1'($urandom_range(1));
		c.use_immediate = ($urandom_range(99) < 30);
		c.thumb_mode = ($urandom_range(99) < 20);
		c.operand_field = 12'($urandom);
		c.first_value = random_word();
		c.second_value = random_word();
		case ($urandom_range(5))
			0: c.shift_byte = 8'd0;
			1: c.shift_byte = 8'd32;
			2: c.shift_byte = {3'($urandom_range(7)), 5'd0};
			3: c.shift_byte = 8'($urandom_range(33, 255));
			default: c.shift_byte = 8'($urandom_range(1, 31));
		endcase
		c.flags_in = 4'($urandom_range(15));
		return c;
	endfunction

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// Rotated immediates, an unrotated one, and the raw thumb field.
	task automatic test_operand2_immediate();
		send_beat(make_instr(COND_AL, OP_ADD, 1'b1, 1'b1, {4'd4, 8'hff},
			32'h0100_0000, 32'h0, 8'd0, 4'b0000, 1'b0));
		send_beat(make_instr(COND_AL, OP_MOV, 1'b1, 1'b1, {4'd0, 8'h80},
			32'h0, 32'h0, 8'd0, 4'b0010, 1'b0));
		send_beat(make_instr(COND_AL, OP_BIC, 1'b1, 1'b1, {4'hf, 8'h01},
			32'hffff_ffff, 32'h0, 8'd0, 4'b0010, 1'b0));
		send_beat(make_instr(COND_ALWAYS, OP_ORR, 1'b1, 1'b1, 12'hfff,
			32'h0, 32'h0, 8'd0, 4'b0010, 1'b1));
	endtask

	// Immediate shift amounts, the zero-amount encodings among them.
	task automatic test_shift_by_amount();
		send_beat(make_instr(COND_AL, OP_AND, 1'b1, 1'b0, shift_by_amount(5'd0, SH_LSL),
			32'hffff_ffff, 32'h8000_0000, 8'd0, 4'b0010, 1'b0));
		send_beat(make_instr(COND_AL, OP_EOR, 1'b1, 1'b0, shift_by_amount(5'd0, SH_LSR),
			32'h0, 32'h8000_0001, 8'd0, 4'b0000, 1'b0));
		send_beat(make_instr(COND_AL, OP_SUB, 1'b1, 1'b0, shift_by_amount(5'd0, SH_ASR),
			32'h0, 32'h8000_0000, 8'd0, 4'b0000, 1'b0));
		send_beat(make_instr(COND_AL, OP_RSB, 1'b1, 1'b0, shift_by_amount(5'd0, SH_ROR),
			32'h0, 32'h0000_0001, 8'd0, 4'b0010, 1'b0));
		send_beat(make_instr(COND_AL, OP_ADC, 1'b1, 1'b0, shift_by_amount(5'd31, SH_LSL),
			32'h7fff_ffff, 32'h0000_0001, 8'd0, 4'b0010, 1'b0));
		send_beat(make_instr(COND_AL, OP_SBC, 1'b1, 1'b0, shift_by_amount(5'd1, SH_ASR),
			32'h8000_0000, 32'hffff_ffff, 8'd0, 4'b0000, 1'b0));
	endtask

	// Shift byte of zero, exactly 32, beyond 32, and rotations past a word.
	task automatic test_shift_by_register();
		send_beat(make_instr(COND_AL, OP_RSC, 1'b1, 1'b0, shift_by_byte(SH_ROR),
			32'h0, 32'h1234_5678, 8'd0, 4'b0010, 1'b0));
		send_beat(make_instr(COND_AL, OP_TST, 1'b1, 1'b0, shift_by_byte(SH_LSL),
			32'hffff_ffff, 32'h0000_0001, 8'd32, 4'b0000, 1'b0));
		send_beat(make_instr(COND_AL, OP_TEQ, 1'b1, 1'b0, shift_by_byte(SH_LSR),
			32'h0, 32'h8000_0000, 8'd32, 4'b0000, 1'b0));
		send_beat(make_instr(COND_AL, OP_CMP, 1'b1, 1'b0, shift_by_byte(SH_LSL),
			32'h0, 32'hffff_ffff, 8'd40, 4'b1111, 1'b0));
		send_beat(make_instr(COND_AL, OP_CMN, 1'b1, 1'b0, shift_by_byte(SH_LSR),
			32'hffff_ffff, 32'hffff_ffff, 8'd255, 4'b0010, 1'b0));
		send_beat(make_instr(COND_AL, OP_MVN, 1'b1, 1'b0, shift_by_byte(SH_ASR),
			32'h0, 32'h8000_0000, 8'd200, 4'b0000, 1'b0));
		send_beat(make_instr(COND_AL, OP_MOV, 1'b1, 1'b0, shift_by_byte(SH_ROR),
			32'h0, 32'h8000_0001, 8'd64, 4'b0000, 1'b0));
		send_beat(make_instr(COND_AL, OP_ORR, 1'b1, 1'b0, shift_by_byte(SH_ROR),
			32'h0, 32'h0000_0003, 8'd33, 4'b0000, 1'b0));
		send_beat(make_instr(COND_AL, OP_ADD, 1'b0, 1'b0, shift_by_byte(SH_ROR),
			32'h0000_0001, 32'hffff_ffff, 8'd5, 4'b0101, 1'b0));
	endtask

	// Conditions that fail and pass on chosen flags.
	task automatic test_condition_codes();
		send_beat(make_instr(COND_EQ, OP_ADD, 1'b1, 1'b0, shift_by_amount(5'd0, SH_LSL),
			32'hffff_ffff, 32'hffff_ffff, 8'd0, 4'b1011, 1'b0));
		send_beat(make_instr(COND_LE, OP_SUB, 1'b1, 1'b0, shift_by_amount(5'd0, SH_LSL),
			32'h5, 32'h5, 8'd0, 4'b0100, 1'b0));
		send_beat(make_instr(COND_GT, OP_MOV, 1'b1, 1'b1, 12'h0ff,
			32'h0, 32'h0, 8'd0, 4'b1000, 1'b0));
		send_beat(make_instr(COND_HI, OP_EOR, 1'b1, 1'b0, shift_by_amount(5'd4, SH_ROR),
			32'hdead_beef, 32'h1234_5678, 8'd0, 4'b0010, 1'b0));
	endtask

	// Random instructions at the given sender hold-off rate.
	task automatic test_random_mix(input int count, input int hold_pct);
		sender_hold_pct = hold_pct;
		repeat (count)
			send_beat(random_instr());
	endtask

	// ------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_operand2_immediate();
		test_shift_by_amount();
		test_shift_by_register();
		test_condition_codes();
		drain_outcomes();

		test_random_mix(250, 20);
		drain_outcomes();
		test_random_mix(250, 81);
		drain_outcomes();
		test_random_mix(250, 0);
		drain_outcomes();

		// Allow for any stray beat still in the pipeline.
		repeat (4) @(posedge clk);
		if (mismatch_count == 0 && outcomes_due.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: cond_alu_with_barrel_shifter.f
hdl/calu_pkg.sv
hdl/calu_shifter.sv
hdl/calu_alu.sv
hdl/cond_alu_with_barrel_shifter.sv
tb/tb.sv
